/* src/ttint_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// ttint_pkg
// Shared widths, codes and types of the thermistor table interpolator.
// -----------------------------------------------------------------------------
package ttint_pkg;

  localparam int ADC_W    = 10;
  localparam int TEMP_W   = 16;
  localparam int SEL_W    = 2;
  localparam int IDX_W    = 5;
  localparam int STATUS_W = 2;
  // (x - x0) * y1 + (x1 - x) * y0 never exceeds (x1 - x0) * 65535 < 2^26
  localparam int NUM_W    = 26;
  localparam int ENTRY_W  = ADC_W + TEMP_W;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INTERP = 2'd0,
    STATUS_HIGH   = 2'd1,
    STATUS_LOW    = 2'd2
  } status_e;

  typedef struct packed {
    logic [ADC_W-1:0]  adc;
    logic [TEMP_W-1:0] temp;
  } entry_t;

endpackage
`default_nettype wire

/* src/ttint_if.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// ttint_if
// Request and result channels with valid/ready handshake.
// -----------------------------------------------------------------------------
interface ttint_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ttint_pkg::SEL_W-1:0]   table_sel;
  logic [ttint_pkg::IDX_W-1:0]   entry_index;
  logic [ttint_pkg::ADC_W-1:0]   entry_adc;
  logic [ttint_pkg::TEMP_W-1:0]  entry_temp;
  logic [ttint_pkg::ADC_W-1:0]   adc_sample;

  modport source (output valid, req_type, table_sel, entry_index, entry_adc, entry_temp,
                  adc_sample, input ready);
  modport sink   (input valid, req_type, table_sel, entry_index, entry_adc, entry_temp,
                  adc_sample, output ready);
endinterface

interface ttint_res_if;
  logic                           valid;
  logic                           ready;
  logic [ttint_pkg::TEMP_W-1:0]   temperature;
  logic [ttint_pkg::STATUS_W-1:0] range_status;

  modport source (output valid, temperature, range_status, input ready);
  modport sink   (input valid, temperature, range_status, output ready);
endinterface
`default_nettype wire

/* src/ttint_ram.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// ttint_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module ttint_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* src/ttint_mac.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// ttint_mac
// Bit-serial a * ya + b * yb, one bit of both multipliers per cycle, MSB first.
// -----------------------------------------------------------------------------
module ttint_mac (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ttint_pkg::ADC_W-1:0]  a_i,
  input  wire logic [ttint_pkg::ADC_W-1:0]  b_i,
  input  wire logic [ttint_pkg::TEMP_W-1:0] ya_i,
  input  wire logic [ttint_pkg::TEMP_W-1:0] yb_i,
  output logic                              done_o,
  output logic      [ttint_pkg::NUM_W-1:0]  acc_o
);

  localparam int CW = $clog2(ttint_pkg::ADC_W);

  logic                          busy_q;
  logic                          done_q;
  logic [CW-1:0]                 cnt_q;
  logic [ttint_pkg::ADC_W-1:0]   a_q, b_q;
  logic [ttint_pkg::TEMP_W-1:0]  ya_q, yb_q;
  logic [ttint_pkg::NUM_W-1:0]   acc_q, acc_d;

  always_comb begin
    acc_d = {acc_q[ttint_pkg::NUM_W-2:0], 1'b0};
    if (a_q[ttint_pkg::ADC_W-1]) begin
      acc_d = acc_d + ttint_pkg::NUM_W'(ya_q);
    end
    if (b_q[ttint_pkg::ADC_W-1]) begin
      acc_d = acc_d + ttint_pkg::NUM_W'(yb_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      ya_q   <= '0;
      yb_q   <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ttint_pkg::ADC_W - 1);
        a_q    <= a_i;
        b_q    <= b_i;
        ya_q   <= ya_i;
        yb_q   <= yb_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        acc_q <= acc_d;
        a_q   <= {a_q[ttint_pkg::ADC_W-2:0], 1'b0};
        b_q   <= {b_q[ttint_pkg::ADC_W-2:0], 1'b0};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

/* src/ttint_div.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// ttint_div
// Restoring divider, one quotient bit per cycle, truncating.
// -----------------------------------------------------------------------------
module ttint_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [ttint_pkg::NUM_W-1:0] num_i,
  input  wire logic [ttint_pkg::ADC_W-1:0] den_i,
  output logic                             done_o,
  output logic      [ttint_pkg::NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(ttint_pkg::NUM_W);

  logic                          busy_q;
  logic                          done_q;
  logic [CW-1:0]                 cnt_q;
  logic [ttint_pkg::NUM_W-1:0]   n_q;
  logic [ttint_pkg::ADC_W-1:0]   r_q, r_d;
  logic [ttint_pkg::ADC_W-1:0]   den_q;
  logic [ttint_pkg::ADC_W:0]     trial, diff;
  logic                          ge;

  always_comb begin
    trial = {r_q, n_q[ttint_pkg::NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
    r_d   = ge ? diff[ttint_pkg::ADC_W-1:0] : trial[ttint_pkg::ADC_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      n_q    <= '0;
      r_q    <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ttint_pkg::NUM_W - 1);
        n_q    <= num_i;
        r_q    <= '0;
        den_q  <= den_i;
      end else if (busy_q) begin
        r_q <= r_d;
        n_q <= {n_q[ttint_pkg::NUM_W-2:0], ge};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule
`default_nettype wire

/* src/thermistor_table_interpolator.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// thermistor_table_interpolator
// ADC sample to 14.2 temperature by linear interpolation in stored tables.
// -----------------------------------------------------------------------------
// A load beat writes one table entry in the cycle it is accepted and returns
// nothing. A convert beat walks the chosen table one entry per cycle through
// the single read port of the table RAM, then forms the interpolation
// numerator in a bit-serial multiply-accumulate and divides it in a
// restoring divider; clamped samples finish once the walk decides. One beat
// is in flight at a time; the result sits in an output register, so the next
// beat is taken while it waits. Table contents are undefined until loaded.
// -----------------------------------------------------------------------------
module thermistor_table_interpolator #(
  parameter int ENTRIES = 32,
  parameter int TABLES  = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ttint_req_if.sink  req_i,
  ttint_res_if.source res_o
);

  localparam int DEPTH = TABLES * ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $clog2(ENTRIES);
  localparam logic [EW-1:0] LAST = EW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MAC,
    ST_DIV,
    ST_RESULT
  } state_e;

  state_e                             state_q;
  logic [AW-1:0]                      base_q;
  logic [EW-1:0]                      cnt_q, e_q;
  logic                               dv_q;
  logic [ttint_pkg::ADC_W-1:0]        x_q;
  ttint_pkg::entry_t                  prev_q;
  logic [ttint_pkg::ADC_W-1:0]        den_q;
  logic [ttint_pkg::TEMP_W-1:0]       pend_temp_q;
  ttint_pkg::status_e                 pend_status_q;
  logic                               out_valid_q;
  logic [ttint_pkg::TEMP_W-1:0]       out_temp_q;
  ttint_pkg::status_e                 out_status_q;

  logic                               accept;
  logic                               sel_ok;
  logic                               wr_en;
  logic [AW-1:0]                      wr_addr, rd_addr;
  ttint_pkg::entry_t                  wr_data, rd_data;
  logic                               rd_en;
  logic                               scan_hit;
  logic                               mac_done, div_done;
  logic [ttint_pkg::NUM_W-1:0]        mac_acc, quo;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign sel_ok      = (32'(req_i.table_sel) < TABLES);
  assign wr_en       = accept && (req_i.req_type == ttint_pkg::REQ_LOAD) && sel_ok &&
                       (32'(req_i.entry_index) < ENTRIES);
  assign wr_addr     = AW'(32'(req_i.table_sel) * ENTRIES + 32'(req_i.entry_index));
  assign wr_data     = '{adc: req_i.entry_adc, temp: req_i.entry_temp};
  assign rd_en       = (state_q == ST_SCAN);
  assign rd_addr     = base_q + AW'(cnt_q);
  assign scan_hit    = (state_q == ST_SCAN) && dv_q && (e_q != '0) && (rd_data.adc > x_q);

  ttint_ram #(
    .WIDTH (ttint_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  ttint_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_hit),
    .a_i     (x_q - prev_q.adc),
    .b_i     (rd_data.adc - x_q),
    .ya_i    (rd_data.temp),
    .yb_i    (prev_q.temp),
    .done_o  (mac_done),
    .acc_o   (mac_acc)
  );

  ttint_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_done && (state_q == ST_MAC)),
    .num_i   (mac_acc),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      base_q        <= '0;
      cnt_q         <= '0;
      e_q           <= '0;
      dv_q          <= 1'b0;
      x_q           <= '0;
      prev_q        <= '0;
      den_q         <= '0;
      pend_temp_q   <= '0;
      pend_status_q <= ttint_pkg::STATUS_INTERP;
      out_valid_q   <= 1'b0;
      out_temp_q    <= '0;
      out_status_q  <= ttint_pkg::STATUS_INTERP;
    end else begin
      if (out_valid_q && res_o.ready && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept && (req_i.req_type == ttint_pkg::REQ_CONVERT)) begin
            if (sel_ok) begin
              base_q  <= AW'(32'(req_i.table_sel) * ENTRIES);
              cnt_q   <= '0;
              dv_q    <= 1'b0;
              x_q     <= req_i.adc_sample;
              state_q <= ST_SCAN;
            end else begin
              pend_temp_q   <= '0;
              pend_status_q <= ttint_pkg::STATUS_INTERP;
              state_q       <= ST_RESULT;
            end
          end
        end
        ST_SCAN: begin
          if (cnt_q != LAST) begin
            cnt_q <= cnt_q + 1'b1;
          end
          dv_q <= 1'b1;
          e_q  <= cnt_q;
          if (dv_q) begin
            if (e_q == '0) begin
              if (x_q < rd_data.adc) begin
                pend_temp_q   <= rd_data.temp;
                pend_status_q <= ttint_pkg::STATUS_LOW;
                state_q       <= ST_RESULT;
              end else begin
                prev_q <= rd_data;
              end
            end else if (scan_hit) begin
              den_q   <= rd_data.adc - prev_q.adc;
              state_q <= ST_MAC;
            end else begin
              prev_q <= rd_data;
              if (e_q == LAST) begin
                pend_temp_q   <= rd_data.temp;
                pend_status_q <= ttint_pkg::STATUS_HIGH;
                state_q       <= ST_RESULT;
              end
            end
          end
        end
        ST_MAC: begin
          if (mac_done) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            pend_temp_q   <= quo[ttint_pkg::TEMP_W-1:0];
            pend_status_q <= ttint_pkg::STATUS_INTERP;
            state_q       <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q  <= 1'b1;
            out_temp_q   <= pend_temp_q;
            out_status_q <= pend_status_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.temperature  = out_temp_q;
  assign res_o.range_status = out_status_q;

endmodule
`default_nettype wire

/* sim/thermistor_table_interpolator_tb.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// thermistor_table_interpolator_tb
// Loads all thermistor tables, converts samples against them and checks each
// reading against a local interpolation of the same table contents. Requests
// come in bursts with random gaps and readings are stalled on a pattern of
// their own, including one long hold that backs the block up.
// -----------------------------------------------------------------------------
module thermistor_table_interpolator_tb;

  localparam int     ENTRIES       = 32;
  localparam int     TABLES        = 4;
  localparam int     RANDOM_ITEMS  = 940;
  localparam int     LONG_HOLD     = 400;
  localparam int     SETTLE_CYCLES = ENTRIES + 64;
  localparam longint RUN_LIMIT_NS  = 20_000_000;

  localparam int     ADC_W    = ttint_pkg::ADC_W;
  localparam int     TEMP_W   = ttint_pkg::TEMP_W;
  localparam int     SEL_W    = ttint_pkg::SEL_W;
  localparam int     IDX_W    = ttint_pkg::IDX_W;
  localparam int     STATUS_W = ttint_pkg::STATUS_W;

  typedef struct packed {
    logic [TEMP_W-1:0]  temperature;
    ttint_pkg::status_e range_status;
  } reading_t;

  logic clk;
  logic rst_n;

  ttint_req_if req_if ();
  ttint_res_if res_if ();

  thermistor_table_interpolator #(
    .ENTRIES(ENTRIES),
    .TABLES (TABLES)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .res_o (res_if)
  );

  ttint_pkg::entry_t table_image [TABLES][ENTRIES];
  reading_t          pending_readings [$];
  int unsigned       mismatches;
  int unsigned       beats_sent;
  int unsigned       tx_burst_left;
  bit                long_hold_req;
  bit                rx_level;
  int unsigned       rx_run_left;
  int unsigned       rx_hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  function automatic reading_t interpolate_sample(input logic [SEL_W-1:0] sel,
                                                  input logic [ADC_W-1:0] x);
    reading_t    r;
    bit          found;
    int unsigned xv, x0, x1, y0, y1;
    found          = 1'b0;
    xv             = 32'(x);
    r.temperature  = table_image[sel][ENTRIES-1].temp;
    r.range_status = ttint_pkg::STATUS_HIGH;
    if (x < table_image[sel][0].adc) begin
      r.temperature  = table_image[sel][0].temp;
      r.range_status = ttint_pkg::STATUS_LOW;
    end else begin
      for (int j = 1; j < ENTRIES; j++) begin
        if (!found && table_image[sel][j].adc > x) begin
          found          = 1'b1;
          x0             = 32'(table_image[sel][j-1].adc);
          x1             = 32'(table_image[sel][j].adc);
          y0             = 32'(table_image[sel][j-1].temp);
          y1             = 32'(table_image[sel][j].temp);
          r.temperature  = TEMP_W'(((xv - x0) * y1 + (x1 - xv) * y0) / (x1 - x0));
          r.range_status = ttint_pkg::STATUS_INTERP;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic check_reading(input logic [TEMP_W-1:0] temperature,
                               input logic [STATUS_W-1:0] range_status);
    reading_t want;
    if (pending_readings.size() == 0) begin
      report_mismatch("reading with none pending", 32'(temperature), 0);
    end else begin
      want = pending_readings.pop_front();
      if (temperature !== want.temperature) begin
        report_mismatch("temperature", 32'(temperature), 32'(want.temperature));
      end
      if (range_status !== want.range_status) begin
        report_mismatch("range_status", 32'(range_status), 32'(want.range_status));
      end
    end
  endtask

  // readings: check each beat, stall on a random run-length pattern
  always @(posedge clk) begin
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      check_reading(res_if.temperature, res_if.range_status);
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      res_if.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_hold_left  = LONG_HOLD - 1;
      res_if.ready <= 1'b0;
    end else begin
      if (rx_run_left == 0) begin
        rx_level    = ($urandom_range(0, 9) >= 4);
        rx_run_left = rx_level ? (($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 8))
                               : $urandom_range(1, 10);
      end
      rx_run_left--;
      res_if.ready <= rx_level;
    end
  end

  task automatic offer_request(input logic req_type, input logic [SEL_W-1:0] sel,
                               input logic [IDX_W-1:0] idx, input logic [ADC_W-1:0] adc,
                               input logic [TEMP_W-1:0] temp,
                               input logic [ADC_W-1:0] sample);
    int unsigned gap;
    gap = 0;
    if (tx_burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_burst_left = 40;
      end else begin
        tx_burst_left = $urandom_range(1, 12);
        gap           = $urandom_range(0, 9);
      end
    end
    tx_burst_left--;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.req_type    <= req_type;
    req_if.table_sel   <= sel;
    req_if.entry_index <= idx;
    req_if.entry_adc   <= adc;
    req_if.entry_temp  <= temp;
    req_if.adc_sample  <= sample;
    req_if.valid       <= 1'b1;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    beats_sent++;
    if (req_type == ttint_pkg::REQ_LOAD) begin
      table_image[sel][idx] = '{adc: adc, temp: temp};
    end else begin
      pending_readings.push_back(interpolate_sample(sel, sample));
    end
  endtask

  task automatic load_entry(input logic [SEL_W-1:0] sel, input logic [IDX_W-1:0] idx,
                            input logic [ADC_W-1:0] adc, input logic [TEMP_W-1:0] temp);
    offer_request(ttint_pkg::REQ_LOAD, sel, idx, adc, temp, ADC_W'($urandom));
  endtask

  task automatic convert_sample(input logic [SEL_W-1:0] sel, input logic [ADC_W-1:0] x);
    offer_request(ttint_pkg::REQ_CONVERT, sel, IDX_W'($urandom), ADC_W'($urandom),
                  TEMP_W'($urandom), x);
  endtask

  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  // falling, rising, plateau and unordered tables, all entries written
  task automatic test_table_load();
    for (int i = 0; i < ENTRIES; i++) begin
      load_entry(2'd0, IDX_W'(i), ADC_W'(16 + i * 32),
                 TEMP_W'((i == ENTRIES - 1) ? 0 : 65535 - i * 2114));
      load_entry(2'd1, IDX_W'(i), ADC_W'(i * 33),
                 TEMP_W'((i == ENTRIES - 1) ? 65535 : i * 2114));
      load_entry(2'd2, IDX_W'(i), ADC_W'(100 + (i / 2) * 50), TEMP_W'($urandom));
      load_entry(2'd3, IDX_W'(i), ADC_W'($urandom), TEMP_W'($urandom));
    end
  endtask

  task automatic test_directed_conversions();
    convert_sample(0, 0);
    convert_sample(0, 15);
    convert_sample(0, 16);
    convert_sample(0, 17);
    convert_sample(0, 48);
    convert_sample(0, 500);
    convert_sample(0, 1007);
    convert_sample(0, 1008);
    convert_sample(0, 1023);
    convert_sample(1, 0);
    convert_sample(1, 1);
    convert_sample(1, 511);
    convert_sample(1, 1022);
    convert_sample(1, 1023);
    convert_sample(2, 99);
    convert_sample(2, 100);
    convert_sample(2, 150);
    convert_sample(2, 849);
    convert_sample(2, 850);
    convert_sample(3, 0);
    convert_sample(3, 512);
    convert_sample(3, 1023);
    wait_for_drain();
  endtask

  // hold readings off long enough for the block to stall its requests
  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    repeat (12) convert_sample(SEL_W'($urandom), ADC_W'($urandom));
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    int unsigned target, pick, sel, idx, lo, hi, adc, temp, step;
    int          near;
    bit          falling;
    target = beats_sent + RANDOM_ITEMS;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, TABLES - 1);
      if (pick == 0) begin
        adc     = $urandom_range(0, 80);
        temp    = $urandom_range(0, 65535);
        falling = ($urandom_range(0, 1) == 1);
        for (int i = 0; i < ENTRIES; i++) begin
          load_entry(SEL_W'(sel), IDX_W'(i), ADC_W'(adc), TEMP_W'(temp));
          adc  = adc + $urandom_range(0, 40);
          adc  = (adc > 1023) ? 1023 : adc;
          step = $urandom_range(0, 4095);
          if (falling) begin
            temp = (temp > step) ? temp - step : 0;
          end else begin
            temp = (temp + step > 65535) ? 65535 : temp + step;
          end
        end
      end else if (pick < 20) begin
        idx = $urandom_range(0, ENTRIES - 1);
        if ($urandom_range(0, 3) == 0) begin
          load_entry(SEL_W'(sel), IDX_W'(idx), ADC_W'($urandom), TEMP_W'($urandom));
        end else begin
          lo = (idx > 0) ? 32'(table_image[sel][idx-1].adc) : 0;
          hi = (idx < ENTRIES - 1) ? 32'(table_image[sel][idx+1].adc) : 1023;
          load_entry(SEL_W'(sel), IDX_W'(idx), ADC_W'($urandom_range(lo, hi)),
                     TEMP_W'($urandom));
        end
      end else if ($urandom_range(0, 1) == 0) begin
        convert_sample(SEL_W'(sel), ADC_W'($urandom));
      end else begin
        near = int'(table_image[sel][$urandom_range(0, ENTRIES - 1)].adc)
               + int'($urandom_range(0, 2)) - 1;
        near = (near < 0) ? 0 : ((near > 1023) ? 1023 : near);
        convert_sample(SEL_W'(sel), ADC_W'(near));
      end
      if ($urandom_range(0, 199) == 0) begin
        wait_for_drain();
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.req_type    = ttint_pkg::REQ_LOAD;
    req_if.table_sel   = '0;
    req_if.entry_index = '0;
    req_if.entry_adc   = '0;
    req_if.entry_temp  = '0;
    req_if.adc_sample  = '0;
    res_if.ready       = 1'b0;
    mismatches         = 0;
    beats_sent         = 0;
    tx_burst_left      = 0;
    long_hold_req      = 1'b0;
    rx_level           = 1'b0;
    rx_run_left        = 0;
    rx_hold_left       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_load();
    test_directed_conversions();
    test_output_backpressure();
    test_random_traffic();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
